/* rtl/tga_pkg.sv */
// Package for the uncompressed TGA decoder: widths, codes and status values.
// No dependencies.
package tga_pkg;
	localparam int MAX_PIXELS = 65536;
	localparam int ADDR_W = $clog2(MAX_PIXELS);
	localparam int HDR_LEN = 18;

	typedef enum logic {OP_BYTE = 1'b0, OP_FETCH = 1'b1} op_t;
	typedef enum logic {KIND_STATUS = 1'b0, KIND_PIXEL = 1'b1} kind_t;
	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_CMAP = 3'd1, ST_TYPE = 3'd2, ST_DEPTH = 3'd3,
		ST_ZERO = 3'd4, ST_TRUNC = 3'd5, ST_BIG = 3'd6, ST_NOIMG = 3'd7
	} status_t;
	typedef enum logic [1:0] {S_IDLE, S_NEED, S_CHECK, S_READ} state_t;
endpackage

/* rtl/tga_uncompressed_decoder_top.sv */
// Top level of the uncompressed TGA decoder (truecolor and grayscale).
// Depends on tga_pkg.
//
// Input channel: one word per file byte (operation 0) or one fetch request
// (operation 1), valid/stall handshake. Output channel: status words and
// pixel words, valid/stall handshake, held while stalled.
// A file byte that is not end_of_file gives no word; any pixel store write
// happens at its accepting edge. The end_of_file byte runs the
// width*height multiply as it is taken, the need multiply in S_NEED, then
// the checks in S_CHECK, which register the status word. A fetch with an
// image reads the store when accepted (address registered ahead from the
// fetch position), then fills the output register; else it gives ST_NOIMG.
// Items are processed one at a time; input stall is high while one is in
// flight or while the output register still holds an untaken word.
// Reset clears the header, counters and image valid flag; the pixel store
// is not cleared and is only read at entries written by the current image.
// When the receiver stalls the output word holds and no new item enters.
module tga_uncompressed_decoder_top
	import tga_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [2:0]  status,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic        last_pixel
);
	logic [31:0] mem [MAX_PIXELS];
	logic [31:0] rd_q;

	state_t state_q, state_d;
	logic [31:0] fcnt_q;
	logic [7:0]  hdr_q [HDR_LEN];
	logic [1:0]  phase_q;
	logic [23:0] part_q;
	logic [24:0] pw_q;
	logic        img_q;
	logic [15:0] frow_q, fcol_q;
	logic [31:0] area_q;
	logic [33:0] need_q;
	logic        last_q;
	logic        ov_q;

	logic [15:0] w, h;
	logic [7:0]  typ, dep;
	logic [2:0]  nb;
	logic        acc;
	logic        wr_en;
	logic [31:0] wr_data;
	logic [15:0] srow;
	logic [31:0] idx;

	assign w = {hdr_q[13], hdr_q[12]};
	assign h = {hdr_q[15], hdr_q[14]};
	assign typ = hdr_q[2];
	assign dep = hdr_q[16];

	always_comb begin
		nb = 3'd0;
		if (typ == 8'd2 && dep == 8'd24) nb = 3'd3;
		else if (typ == 8'd2 && dep == 8'd32) nb = 3'd4;
		else if (typ == 8'd3 && dep == 8'd8) nb = 3'd1;
	end

	assign in_stall = (state_q != S_IDLE) || (ov_q && out_stall);
	assign acc = in_valid && !in_stall;

	logic pix_byte, pix_done;
	assign pix_byte = acc && operation == OP_BYTE && fcnt_q >= 32'(HDR_LEN)
		&& fcnt_q >= 32'(HDR_LEN) + {24'd0, hdr_q[0]} && nb != 3'd0;
	assign pix_done = pix_byte && ({1'b0, phase_q} + 3'd1 >= nb);

	always_comb begin
		if (nb == 3'd1)
			wr_data = {8'hFF, data_byte, data_byte, data_byte};
		else
			wr_data = {(nb == 3'd4) ? data_byte : 8'hFF, part_q[7:0], part_q[15:8],
				(nb == 3'd3) ? data_byte : part_q[23:16]};
		wr_en = pix_done && ({7'd0, pw_q} < 32'(w) * 32'(h))
			&& (pw_q < 25'(MAX_PIXELS));
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[pw_q[ADDR_W-1:0]] <= wr_data;
		rd_q <= mem[idx[ADDR_W-1:0]];
	end

	assign srow = hdr_q[17][5] ? frow_q : 16'(h - 16'd1 - frow_q);
	logic [31:0] idx_s1;
	always_ff @(posedge clk) idx_s1 <= 32'(srow) * 32'(w) + 32'(fcol_q);
	assign idx = idx_s1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc && operation == OP_FETCH && img_q) state_d = S_READ;
				else if (acc && operation == OP_BYTE && end_of_file) state_d = S_NEED;
			end
			S_NEED: state_d = S_CHECK;
			S_CHECK: state_d = S_IDLE;
			S_READ: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	logic [2:0] st;
	always_comb begin
		if (fcnt_q < 32'(HDR_LEN)) st = ST_TRUNC;
		else if (hdr_q[1] != 8'd0) st = ST_CMAP;
		else if (typ != 8'd2 && typ != 8'd3) st = ST_TYPE;
		else if (nb == 3'd0) st = ST_DEPTH;
		else if (w == 16'd0 || h == 16'd0) st = ST_ZERO;
		else if (need_q > {2'd0, fcnt_q}) st = ST_TRUNC;
		else if (area_q > 32'(MAX_PIXELS)) st = ST_BIG;
		else st = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fcnt_q <= '0;
			for (int i = 0; i < HDR_LEN; i++) hdr_q[i] <= '0;
			phase_q <= '0;
			part_q <= '0;
			pw_q <= '0;
			img_q <= 1'b0;
			frow_q <= '0;
			fcol_q <= '0;
			ov_q <= 1'b0;
			result_kind <= KIND_STATUS;
			status <= '0;
			image_width <= '0;
			image_height <= '0;
			red <= '0; green <= '0; blue <= '0; alpha <= '0;
			last_pixel <= 1'b0;
			area_q <= '0;
			need_q <= '0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ov_q && !out_stall) ov_q <= 1'b0;
			if (acc && operation == OP_BYTE) begin
				if (fcnt_q == 32'd0) begin
					img_q <= 1'b0;
					frow_q <= '0;
					fcol_q <= '0;
				end
				if (fcnt_q < 32'(HDR_LEN)) hdr_q[fcnt_q[4:0]] <= data_byte;
				if (fcnt_q != 32'hFFFF_FFFF) fcnt_q <= fcnt_q + 32'd1;
				if (pix_byte) begin
					if (pix_done) begin
						phase_q <= '0;
						part_q <= '0;
						if (wr_en) pw_q <= pw_q + 25'd1;
					end else begin
						phase_q <= phase_q + 2'd1;
						part_q <= part_q | (24'(data_byte) << (5'd8 * {3'd0, phase_q}));
					end
				end
			end
			if (acc && operation == OP_FETCH && !img_q) begin
				ov_q <= 1'b1;
				result_kind <= KIND_STATUS;
				status <= ST_NOIMG;
				image_width <= '0; image_height <= '0;
				red <= '0; green <= '0; blue <= '0; alpha <= '0;
				last_pixel <= 1'b0;
			end
			if (acc && operation == OP_FETCH && img_q) begin
				if (32'(fcol_q) + 32'd1 >= 32'(w)) begin
					fcol_q <= '0;
					if (32'(frow_q) + 32'd1 >= 32'(h)) begin
						last_q <= 1'b1;
						frow_q <= '0;
					end else begin
						last_q <= 1'b0;
						frow_q <= frow_q + 16'd1;
					end
				end else begin
					last_q <= 1'b0;
					fcol_q <= fcol_q + 16'd1;
				end
			end
			if (acc && operation == OP_BYTE && end_of_file) begin
				area_q <= 32'(w) * 32'(h);
				phase_q <= '0;
				part_q <= '0;
				pw_q <= '0;
			end
			if (state_q == S_NEED)
				need_q <= 34'(HDR_LEN) + 34'(hdr_q[0]) + {2'd0, area_q} * {31'd0, nb};
			if (state_q == S_CHECK) begin
				ov_q <= 1'b1;
				result_kind <= KIND_STATUS;
				status <= st;
				image_width <= (st == ST_OK) ? w : 16'd0;
				image_height <= (st == ST_OK) ? h : 16'd0;
				red <= '0; green <= '0; blue <= '0; alpha <= '0;
				last_pixel <= 1'b0;
				img_q <= (st == ST_OK);
				frow_q <= '0;
				fcol_q <= '0;
				fcnt_q <= '0;
			end
			if (state_q == S_READ) begin
				ov_q <= 1'b1;
				result_kind <= KIND_PIXEL;
				status <= ST_OK;
				image_width <= w;
				image_height <= h;
				red <= (idx < 32'(MAX_PIXELS)) ? rd_q[7:0] : 8'd0;
				green <= (idx < 32'(MAX_PIXELS)) ? rd_q[15:8] : 8'd0;
				blue <= (idx < 32'(MAX_PIXELS)) ? rd_q[23:16] : 8'd0;
				alpha <= (idx < 32'(MAX_PIXELS)) ? rd_q[31:24] : 8'd0;
				last_pixel <= last_q;
			end
		end
	end

	assign out_valid = ov_q;
endmodule
